>>> src/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Largest window the sorted store can hold
  localparam int WINDOW_MAX = 64;

  // Sample width in bits
  localparam int SAMPLE_BITS = 32;

  // Width of the window size register
  localparam int CFG_BITS = 7;

  // Window size after reset
  localparam int WINDOW_RESET = 3;

endpackage

`default_nettype wire

>>> src/sliding_window_median.sv
// Channel      | Direction | Handshake                    | Payload
// -------------+-----------+------------------------------+--------------------------------------
// sample in    | in        | s_axis_tvalid / s_axis_tready | tdata: sample; tuser: restart
// middles out  | out       | m_axis_tvalid / m_axis_tready | tdata: lower_middle, upper_middle
// window size  | in        | window_size_we_i              | window_size_i (write only)
//
// One sample word is taken per clock while s_axis_tready is high. The sorted
// store is a row of cells that compare against the new sample and shift in
// parallel, so the whole store is updated at once; the middle values are
// tapped from it in the cycle after the update and written into the output queue.
// A three-word output queue decouples the two sides: the input stalls only
// when that queue plus the word in flight would overflow.
// Reset (asynchronous, active low) empties the window and sets the window
// size to three; a window size write also empties the window.

`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,

  // window size register
  input  wire logic                                   window_size_we_i,
  input  wire logic [swm_pkg::CFG_BITS-1:0]           window_size_i,

  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, zero fill above
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // [0] restart
  input  wire logic                                   s_axis_tuser,

  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // [SAMPLE_BITS-1:0] lower_middle, [2*SAMPLE_BITS-1:SAMPLE_BITS] upper_middle,
  // zero fill above
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata
);

  localparam int IdxW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CntW   = $clog2(WINDOW_MAX + 1);
  localparam int OutW   = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int WinRst = (swm_pkg::WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                               : swm_pkg::WINDOW_RESET;
  localparam int LoRst  = (WinRst - 1) / 2;
  localparam int HiRst  = WinRst / 2;
  localparam int FifoDepth = 3;
  localparam int FifoPtrW  = 2;

  // ---------------------------------------------------------------------------
  // Window size: saturate to 1..WINDOW_MAX on write and keep the tap indices
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] cfg_win;
  logic [CntW-1:0] win_q;
  logic [IdxW-1:0] lo_idx_q, hi_idx_q;

  always_comb begin
    if (window_size_i == '0) begin
      cfg_win = CntW'(1);
    end else if (32'(window_size_i) > WINDOW_MAX) begin
      cfg_win = CntW'(WINDOW_MAX);
    end else begin
      cfg_win = CntW'(window_size_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Sorted store: each cell holds a sample and the ring slot it arrived in, so
  // the oldest sample is found by its slot tag and no separate ring is needed
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] val_q [WINDOW_MAX];
  logic        [IdxW-1:0]        tag_q [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] val_d [WINDOW_MAX];
  logic        [IdxW-1:0]        tag_d [WINDOW_MAX];

  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          s_acc;
  logic [CntW-1:0]               fill_eff;
  logic [CntW-1:0]               n_keep;
  logic                          full;
  logic                          res;
  logic [IdxW-1:0]               new_tag;

  logic [WINDOW_MAX-1:0] rm;       // cell holds the evicted sample
  logic [WINDOW_MAX-1:0] below;    // at or above the evicted cell
  logic [WINDOW_MAX-1:0] lt_old;   // new sample sorts before this cell
  logic [WINDOW_MAX-1:0] c_lt;
  logic [WINDOW_MAX-1:0] ins;      // cell takes the sample or the one below
  logic signed [SAMPLE_BITS-1:0] c_val [WINDOW_MAX];
  logic        [IdxW-1:0]        c_tag [WINDOW_MAX];

  assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_acc  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // restart, or a count beyond the window, starts a fresh window
    fill_eff = (s_axis_tuser || (fill_q > win_q)) ? '0 : fill_q;
    full     = (fill_eff == win_q);
    n_keep   = full ? (win_q - CntW'(1)) : fill_eff;
    res      = full || ((fill_eff + CntW'(1)) == win_q);
    new_tag  = full ? ptr_q : IdxW'(fill_eff);

    for (int i = 0; i < WINDOW_MAX; i++) begin
      rm[i]     = full && (CntW'(i) < win_q) && (tag_q[i] == ptr_q);
      lt_old[i] = (sample < val_q[i]);
    end

    for (int i = 0; i < WINDOW_MAX; i++) begin
      below[i] = |(rm & ({WINDOW_MAX{1'b1}} >> (WINDOW_MAX - 1 - i)));
    end

    // close the gap left by the evicted cell
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (below[i] && (i + 1 < WINDOW_MAX)) begin
        c_val[i] = val_q[(i + 1 < WINDOW_MAX) ? i + 1 : i];
        c_tag[i] = tag_q[(i + 1 < WINDOW_MAX) ? i + 1 : i];
        c_lt[i]  = lt_old[(i + 1 < WINDOW_MAX) ? i + 1 : i];
      end else begin
        c_val[i] = val_q[i];
        c_tag[i] = tag_q[i];
        c_lt[i]  = lt_old[i];
      end
    end

    for (int i = 0; i < WINDOW_MAX; i++) begin
      ins[i] = (CntW'(i) < n_keep) ? c_lt[i] : (CntW'(i) == n_keep);
    end

    // open a slot at the insertion point and shift the larger cells up
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (!ins[i]) begin
        val_d[i] = c_val[i];
        tag_d[i] = c_tag[i];
      end else if ((i > 0) && ins[(i > 0) ? i - 1 : 0]) begin
        val_d[i] = c_val[(i > 0) ? i - 1 : 0];
        tag_d[i] = c_tag[(i > 0) ? i - 1 : 0];
      end else begin
        val_d[i] = sample;
        tag_d[i] = new_tag;
      end
    end

    if (full) begin
      fill_d = win_q;
      ptr_d  = ((CntW'(ptr_q) + CntW'(1)) == win_q) ? '0 : (ptr_q + IdxW'(1));
    end else begin
      fill_d = fill_eff + CntW'(1);
      ptr_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      val_q <= val_d;
      tag_q <= tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Tap the middle cells the cycle after an update and queue the result word
  // ---------------------------------------------------------------------------
  logic                          rd_q;
  logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
  logic [2*SAMPLE_BITS-1:0]      fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW-1:0]           cnt_q;
  logic                          pop;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      lo_val = lo_val | (val_q[i] & {SAMPLE_BITS{lo_idx_q == IdxW'(i)}});
      hi_val = hi_val | (val_q[i] & {SAMPLE_BITS{hi_idx_q == IdxW'(i)}});
    end
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = OutW'(fifo_q[rd_ptr_q]);
  // hold off new samples while the queue and the word in flight fill it
  assign s_axis_tready = ((3'(cnt_q) + 3'(rd_q)) < 3'(FifoDepth));

  always_ff @(posedge clk_i) begin
    if (rd_q) begin
      fifo_q[wr_ptr_q] <= {hi_val, lo_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= CntW'(WinRst);
      lo_idx_q <= IdxW'(LoRst);
      hi_idx_q <= IdxW'(HiRst);
      fill_q   <= '0;
      ptr_q    <= '0;
      rd_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (window_size_we_i) begin
        win_q    <= cfg_win;
        lo_idx_q <= IdxW'((cfg_win - CntW'(1)) >> 1);
        hi_idx_q <= IdxW'(cfg_win >> 1);
        fill_q   <= '0;
        ptr_q    <= '0;
      end else if (s_acc) begin
        fill_q <= fill_d;
        ptr_q  <= ptr_d;
      end

      rd_q <= s_acc && res;

      if (rd_q) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_q + FifoPtrW'(rd_q) - FifoPtrW'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_queue_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q |-> (cnt_q < FifoPtrW'(FifoDepth)))
    else $error("result word pushed into a full queue");

  a_one_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && full) |-> $onehot(rm))
    else $error("oldest sample not found exactly once in the sorted store");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q)
    else $error("fill count beyond the window size");

  a_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == win_q) |-> (CntW'(ptr_q) < win_q))
    else $error("oldest pointer outside the window");

endmodule

`default_nettype wire
